// ===== sv/tdf_pkg.sv =====
// shared types, constants and helper functions of the telegram deframer
package tdf_pkg;

  // payload length limit and derived widths
  localparam int MAX_PAYLOAD = 1024;
  localparam int LEN_W       = 16;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int PC_W        = 11;

  // result queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_BYTE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_BYTE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_ADDRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY      = 3'd4;

  // register reset values
  localparam logic [7:0]  START_BYTE_RST    = 8'h02;
  localparam logic [7:0]  ACK_BYTE_RST      = 8'h06;
  localparam logic [7:0]  NAK_BYTE_RST      = 8'h15;
  localparam logic [7:0]  REPLY_ADDRESS_RST = 8'h80;
  localparam logic [15:0] CRC_POLY_RST      = 16'h8005;

  // result kinds
  localparam logic [2:0] KIND_DATA      = 3'd0;
  localparam logic [2:0] KIND_OK        = 3'd1;
  localparam logic [2:0] KIND_CRC_FAIL  = 3'd2;
  localparam logic [2:0] KIND_NAK       = 3'd3;
  localparam logic [2:0] KIND_PARTIAL   = 3'd4;
  localparam logic [2:0] KIND_TOO_LONG  = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [7:0]      data_byte;
    logic [7:0]      message_id;
    logic [PC_W-1:0] payload_count;
    logic            last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  ack_byte;
    logic [7:0]  nak_byte;
    logic [7:0]  reply_address;
    logic [15:0] crc_poly;
  } cfg_t;

  // up to two result words produced by one input word
  typedef struct packed {
    logic [1:0] count;
    out_word_t  r0;
    out_word_t  r1;
  } core_res_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
  } queue_stat_t;

  // telegram phase, one-hot
  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_ADDR    = 7'b0000010,
    PH_LEN_LO  = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CRC_LO  = 7'b0100000,
    PH_CRC_HI  = 7'b1000000
  } phase_t;

  // one crc step mixing current and previous byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                           input logic [15:0] poly,
                                           input logic [7:0]  b,
                                           input logic [7:0]  prev);
    logic [15:0] c;
    c = crc[15] ? ({crc[14:0], 1'b0} ^ poly) : {crc[14:0], 1'b0};
    return c ^ {prev, b};
  endfunction

  // build a result word; last_of_run is set later
  function automatic out_word_t make_result(input logic [2:0]       kind,
                                            input logic [7:0]       data,
                                            input logic [7:0]       id,
                                            input logic [CNT_W-1:0] cnt);
    out_word_t r;
    logic [CNT_W+PC_W-1:0] wide;
    wide            = {{PC_W{1'b0}}, cnt};
    r.kind          = kind;
    r.data_byte     = data;
    r.message_id    = id;
    r.payload_count = wide[PC_W-1:0];
    r.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/tdf_cfg.sv =====
// configuration registers of the telegram deframer
module tdf_cfg
  import tdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output cfg_t                  cfg
);

  // register file with reset values, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= START_BYTE_RST;
      cfg.ack_byte      <= ACK_BYTE_RST;
      cfg.nak_byte      <= NAK_BYTE_RST;
      cfg.reply_address <= REPLY_ADDRESS_RST;
      cfg.crc_poly      <= CRC_POLY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_BYTE:    cfg.start_byte    <= cfg_wr_data[7:0];
        CFG_ACK_BYTE:      cfg.ack_byte      <= cfg_wr_data[7:0];
        CFG_NAK_BYTE:      cfg.nak_byte      <= cfg_wr_data[7:0];
        CFG_REPLY_ADDRESS: cfg.reply_address <= cfg_wr_data[7:0];
        CFG_CRC_POLY:      cfg.crc_poly      <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/tdf_core.sv =====
// telegram phase machine and crc, one received word per step
module tdf_core
  import tdf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_word_t  in_word,
  input  cfg_t      cfg,
  output core_res_t res
);

  phase_t           phase, phase_next;
  logic [15:0]      crc, crc_next;
  logic [7:0]       prev_byte, prev_byte_next;
  logic [7:0]       len_lo, len_lo_next;
  logic [LEN_W-1:0] len, len_next;
  logic [CNT_W-1:0] bytes_seen, bytes_seen_next;
  logic [7:0]       id_byte, id_byte_next;
  logic [7:0]       crc_lo, crc_lo_next;

  logic [7:0]       b;
  logic             hunt;
  logic [LEN_W-1:0] len_full;
  logic [CNT_W-1:0] cnt_inc;
  logic [1:0]       n;
  out_word_t        r0, r1, extra;

  assign b        = in_word.rx_byte;
  assign len_full = {b, len_lo};
  assign cnt_inc  = bytes_seen + CNT_W'(1);

  // next state and results of this word
  always_comb begin
    phase_next      = phase;
    crc_next        = crc;
    prev_byte_next  = prev_byte;
    len_lo_next     = len_lo;
    len_next        = len;
    bytes_seen_next = bytes_seen;
    id_byte_next    = id_byte;
    crc_lo_next     = crc_lo;
    hunt            = 1'b0;
    n               = 2'd0;
    r0              = '0;
    r1              = '0;
    extra           = '0;

    case (phase)
      PH_ADDR: begin
        if (b == cfg.reply_address) begin
          crc_next       = crc_step(crc, cfg.crc_poly, b, prev_byte);
          prev_byte_next = b;
          phase_next     = PH_LEN_LO;
        end else begin
          hunt = 1'b1;
        end
      end
      PH_LEN_LO: begin
        crc_next       = crc_step(crc, cfg.crc_poly, b, prev_byte);
        prev_byte_next = b;
        len_lo_next    = b;
        phase_next     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        crc_next       = crc_step(crc, cfg.crc_poly, b, prev_byte);
        prev_byte_next = b;
        len_next       = len_full;
        if (len_full == '0) begin
          phase_next = PH_HUNT;
        end else if (len_full > LEN_W'(MAX_PAYLOAD)) begin
          r0         = make_result(KIND_TOO_LONG, 8'h00, 8'h00, '0);
          n          = 2'd1;
          phase_next = PH_HUNT;
        end else begin
          bytes_seen_next = '0;
          phase_next      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_next        = crc_step(crc, cfg.crc_poly, b, prev_byte);
        prev_byte_next  = b;
        bytes_seen_next = cnt_inc;
        if (cnt_inc == CNT_W'(1)) begin
          id_byte_next = b;
        end else begin
          r0 = make_result(KIND_DATA, b, id_byte, cnt_inc);
          n  = 2'd1;
        end
        if (LEN_W'(cnt_inc) >= len) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_next = b;
        phase_next  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        if (crc_lo == crc[7:0] && b == crc[15:8]) begin
          r0 = make_result(KIND_OK, 8'h00, id_byte, bytes_seen);
        end else begin
          r0 = make_result(KIND_CRC_FAIL, 8'h00, id_byte, bytes_seen);
        end
        n          = 2'd1;
        phase_next = PH_HUNT;
      end
      PH_HUNT: hunt = 1'b1;
      default: hunt = 1'b1;
    endcase

    // byte seen while hunting: nak before ack before start
    if (hunt) begin
      phase_next = PH_HUNT;
      if (b == cfg.nak_byte) begin
        r0 = make_result(KIND_NAK, 8'h00, 8'h00, '0);
        n  = 2'd1;
      end else if (b == cfg.ack_byte) begin
        phase_next = PH_HUNT;
      end else if (b == cfg.start_byte) begin
        crc_next        = crc_step(16'h0000, cfg.crc_poly, b, 8'h00);
        prev_byte_next  = b;
        len_lo_next     = 8'h00;
        len_next        = '0;
        bytes_seen_next = '0;
        id_byte_next    = 8'h00;
        crc_lo_next     = 8'h00;
        phase_next      = PH_ADDR;
      end
    end

    // chunk end in mid-telegram adds a partial report
    if (in_word.chunk_end && phase_next != PH_HUNT) begin
      extra      = make_result(KIND_PARTIAL, 8'h00, id_byte_next, bytes_seen_next);
      phase_next = PH_HUNT;
      if (n == 2'd0) begin
        r0 = extra;
      end else begin
        r1 = extra;
      end
      n = n + 2'd1;
    end

    // mark the final word of the run
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = (n == 2'd2);
  end

  assign res.count = step ? n : 2'd0;
  assign res.r0    = r0;
  assign res.r1    = r1;

  // state update on accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      crc        <= '0;
      prev_byte  <= '0;
      len_lo     <= '0;
      len        <= '0;
      bytes_seen <= '0;
      id_byte    <= '0;
      crc_lo     <= '0;
    end else if (step) begin
      phase      <= phase_next;
      crc        <= crc_next;
      prev_byte  <= prev_byte_next;
      len_lo     <= len_lo_next;
      len        <= len_next;
      bytes_seen <= bytes_seen_next;
      id_byte    <= id_byte_next;
      crc_lo     <= crc_lo_next;
    end
  end

endmodule

// ===== sv/tdf_queue.sv =====
// result word queue, takes up to two words a cycle and gives one while it is not empty and out_ready is high
module tdf_queue
  import tdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  core_res_t   push,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  output logic        space,
  output queue_stat_t stat
);

  out_word_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0]  level;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_word  = entries[rd_ptr];
  assign space     = (level <= LVL_W'(QUEUE_DEPTH - 2));
  assign stat.level = level;

  // storage, second word goes one slot after the first
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      level  <= level + LVL_W'(push.count) - LVL_W'(pop);
    end
  end

endmodule

// ===== sv/telegram_deframer_crc16.sv =====
// Telegram deframer with 16-bit crc check. One received byte is taken per
// word and handled in the cycle it is accepted: the phase machine and the
// crc update are a single step, so a byte can be accepted every clock. Each
// byte gives zero, one or two result words, which go into a four-word result
// queue; in_ready is high while the queue holds at most two words, so input
// runs at one byte per cycle as long as results are taken one per cycle and
// no more than one result arrives per byte on average. Result words appear
// on the output in the cycle after the byte that caused them at the earliest.
// The user must write configuration registers through the plain write port
// while idle; the block does not enforce it. No clearing pass after reset.
module telegram_deframer_crc16
  import tdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  cfg_t        cfg;
  core_res_t   res;
  queue_stat_t stat;
  logic        step;

  assign step = in_valid && in_ready;

  // configuration registers
  tdf_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  // phase machine and crc
  tdf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_word (in_word),
    .cfg     (cfg),
    .res     (res)
  );

  // result queue
  tdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .space     (in_ready),
    .stat      (stat)
  );

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stat.level <= LVL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // every report other than a data word closes its run and has a cleared data byte
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.kind != KIND_DATA) |->
      (out_word.last_of_run && out_word.data_byte == 8'h00))
    else $error("report word not last of run or carries data");

  // nak and too-long reports carry no telegram context
  a_no_context: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.kind == KIND_NAK || out_word.kind == KIND_TOO_LONG)) |->
      (out_word.message_id == 8'h00 && out_word.payload_count == '0))
    else $error("nak or too-long report carries telegram context");

endmodule
